/* rtl/sip_pkg.sv */
package sip_pkg;

	localparam int NumCells = 15;
	localparam int Stages = NumCells + 3;
	localparam logic [29:0] IdxScale = 30'd10000;
	localparam logic [14:0] NdwiLimit = 15'd10000;
	localparam logic [14:0] BrightMax = 15'd32767;
	localparam logic [32:0] SqrtSatSum = 33'd1073709057;

	typedef struct packed {
		logic [17:0] rem;
		logic [17:0] den;
		logic [14:0] nbits;
		logic [14:0] quo;
		logic        neg;
		logic        zero;
		logic        ovf;
	} sip_div_t;

	typedef struct packed {
		logic [16:0] rem;
		logic [14:0] root;
		logic [29:0] xbits;
		logic        zero;
		logic        sat;
	} sip_sqrt_t;

endpackage

/* rtl/sip_if.sv */
interface sip_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] green_sample;
	logic signed [15:0] red_sample;
	logic signed [15:0] nir_sample;
	logic signed [15:0] swir_sample;
	modport source (output valid, green_sample, red_sample, nir_sample, swir_sample,
		input ready);
	modport sink (input valid, green_sample, red_sample, nir_sample, swir_sample,
		output ready);
endinterface

interface sip_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] ndvi_value;
	logic signed [14:0] ndwi_value;
	logic        [14:0] brightness_value;
	modport source (output valid, ndvi_value, ndwi_value, brightness_value, input ready);
	modport sink (input valid, ndvi_value, ndwi_value, brightness_value, output ready);
endinterface

interface sip_cfg_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/sip_div_cell.sv */
module sip_div_cell (
	input  logic              clk,
	input  logic              en,
	input  sip_pkg::sip_div_t c_in,
	output sip_pkg::sip_div_t c_out
);

	logic [18:0] t;
	logic [18:0] diff;
	logic        take;
	sip_pkg::sip_div_t nxt;

	always_comb begin
		t = {c_in.rem, c_in.nbits[14]};
		diff = t - {1'b0, c_in.den};
		take = (t >= {1'b0, c_in.den});
		nxt = c_in;
		nxt.rem = take ? diff[17:0] : t[17:0];
		nxt.nbits = {c_in.nbits[13:0], 1'b0};
		nxt.quo = {c_in.quo[13:0], take};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_out <= nxt;
		end
	end

endmodule

/* rtl/sip_sqrt_cell.sv */
module sip_sqrt_cell (
	input  logic               clk,
	input  logic               en,
	input  sip_pkg::sip_sqrt_t c_in,
	output sip_pkg::sip_sqrt_t c_out
);

	logic [18:0] t;
	logic [18:0] trial;
	logic [18:0] diff;
	logic        take;
	sip_pkg::sip_sqrt_t nxt;

	always_comb begin
		t = {c_in.rem, c_in.xbits[29:28]};
		trial = {2'b00, c_in.root, 2'b01};
		diff = t - trial;
		take = (t >= trial);
		nxt = c_in;
		nxt.rem = take ? diff[16:0] : t[16:0];
		nxt.root = {c_in.root[13:0], take};
		nxt.xbits = {c_in.xbits[27:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_out <= nxt;
		end
	end

endmodule

/* rtl/spectral_index_pixel_top.sv */
// Path: s1 and s2 registers, row 0 register, 15 cells, then the output register.
// Throughput: one pixel per cycle unless held; the two divider rows and the
// root row each resolve one quotient or root bit per cell, 15 cells deep,
// all in lockstep. The pipeline holds only while its last stage is full and the
// output is blocked. Reset clears the valid bits, the output valid and sets the
// background register bg_q to 0. Payload registers are not reset.
module spectral_index_pixel_top (
	input  logic clk,
	input  logic arst_n,
	sip_in_if.sink    in_ch,
	sip_out_if.source out_ch,
	sip_cfg_if.sink   cfg
);

	localparam int NC = sip_pkg::NumCells;
	localparam int NS = sip_pkg::Stages;

	logic signed [15:0] bg_q;
	logic [NS-1:0] v_q;
	logic          adv;
	logic          out_valid_q;

	logic signed [15:0] g_s1, r_s1, n_s1, w_s1;
	logic               zv_s1, zw_s1, zb_s1;

	logic [15:0] adv_s2, adw_s2;
	logic [16:0] asv_s2, asw_s2;
	logic        negv_s2, negw_s2, zv_s2, zw_s2, zb_s2;
	logic [30:0] sqg_s2, sqr_s2, sqn_s2, sqw_s2;

	logic signed [16:0] dv, sv, dw, sw;
	logic signed [31:0] pg, pr, pn, pw;

	logic [29:0] numv, numw;
	logic [30:0] nv, nw;
	logic [32:0] sum;
	sip_pkg::sip_div_t  dv_in, dw_in;
	sip_pkg::sip_sqrt_t sq_in;

	sip_pkg::sip_div_t  vrow [0:NC];
	sip_pkg::sip_div_t  wrow [0:NC];
	sip_pkg::sip_sqrt_t srow [0:NC];

	logic signed [15:0] ndvi_d, ndvi_q;
	logic signed [14:0] ndwi_d, ndwi_q;
	logic        [14:0] bright_d, bright_q;
	logic        [14:0] mag_w;

	assign adv = !(v_q[NS-1] && out_valid_q && !out_ch.ready);
	assign in_ch.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= '0;
		end else if (cfg.valid) begin
			bg_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1 <= in_ch.green_sample;
			r_s1 <= in_ch.red_sample;
			n_s1 <= in_ch.nir_sample;
			w_s1 <= in_ch.swir_sample;
			zv_s1 <= (in_ch.red_sample == bg_q) || (in_ch.nir_sample == bg_q);
			zw_s1 <= (in_ch.nir_sample == bg_q) || (in_ch.swir_sample == bg_q);
			zb_s1 <= (in_ch.green_sample == bg_q) || (in_ch.red_sample == bg_q)
				|| (in_ch.nir_sample == bg_q) || (in_ch.swir_sample == bg_q);
		end
	end

	always_comb begin
		dv = 17'(n_s1) - 17'(r_s1);
		sv = 17'(n_s1) + 17'(r_s1);
		dw = 17'(n_s1) - 17'(w_s1);
		sw = 17'(n_s1) + 17'(w_s1);
		pg = 32'(g_s1) * 32'(g_s1);
		pr = 32'(r_s1) * 32'(r_s1);
		pn = 32'(n_s1) * 32'(n_s1);
		pw = 32'(w_s1) * 32'(w_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			adv_s2 <= dv[16] ? 16'(-dv) : dv[15:0];
			adw_s2 <= dw[16] ? 16'(-dw) : dw[15:0];
			asv_s2 <= sv[16] ? 17'(-sv) : sv;
			asw_s2 <= sw[16] ? 17'(-sw) : sw;
			negv_s2 <= dv[16] ^ sv[16];
			negw_s2 <= dw[16] ^ sw[16];
			zv_s2 <= zv_s1 || (sv == 17'sd0);
			zw_s2 <= zw_s1 || (sw == 17'sd0);
			zb_s2 <= zb_s1;
			sqg_s2 <= pg[30:0];
			sqr_s2 <= pr[30:0];
			sqn_s2 <= pn[30:0];
			sqw_s2 <= pw[30:0];
		end
	end

	always_comb begin
		numv = 30'(adv_s2) * sip_pkg::IdxScale;
		numw = 30'(adw_s2) * sip_pkg::IdxScale;
		nv = {numv, 1'b0} + 31'(asv_s2);
		nw = {numw, 1'b0} + 31'(asw_s2);
		dv_in.den = {asv_s2, 1'b0};
		dv_in.rem = 18'(nv[30:15]);
		dv_in.nbits = nv[14:0];
		dv_in.quo = '0;
		dv_in.neg = negv_s2;
		dv_in.zero = zv_s2;
		dv_in.ovf = (18'(nv[30:15]) >= {asv_s2, 1'b0});
		dw_in.den = {asw_s2, 1'b0};
		dw_in.rem = 18'(nw[30:15]);
		dw_in.nbits = nw[14:0];
		dw_in.quo = '0;
		dw_in.neg = negw_s2;
		dw_in.zero = zw_s2;
		dw_in.ovf = (18'(nw[30:15]) >= {asw_s2, 1'b0});
		sum = 33'(sqg_s2) + 33'(sqr_s2) + 33'(sqn_s2) + 33'(sqw_s2);
		sq_in.rem = '0;
		sq_in.root = '0;
		sq_in.xbits = sum[29:0];
		sq_in.zero = zb_s2;
		sq_in.sat = (sum >= sip_pkg::SqrtSatSum);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vrow[0] <= dv_in;
			wrow[0] <= dw_in;
			srow[0] <= sq_in;
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_cells
		sip_div_cell u_vcell (.clk(clk), .en(adv), .c_in(vrow[i]), .c_out(vrow[i+1]));
		sip_div_cell u_wcell (.clk(clk), .en(adv), .c_in(wrow[i]), .c_out(wrow[i+1]));
		sip_sqrt_cell u_scell (.clk(clk), .en(adv), .c_in(srow[i]), .c_out(srow[i+1]));
	end

	always_comb begin
		if (vrow[NC].zero) begin
			ndvi_d = '0;
		end else if (vrow[NC].ovf) begin
			ndvi_d = vrow[NC].neg ? 16'sh8000 : 16'sh7fff;
		end else begin
			ndvi_d = vrow[NC].neg ? 16'(16'd0 - {1'b0, vrow[NC].quo})
				: {1'b0, vrow[NC].quo};
		end
		mag_w = (wrow[NC].ovf || wrow[NC].quo > sip_pkg::NdwiLimit)
			? sip_pkg::NdwiLimit : wrow[NC].quo;
		if (wrow[NC].zero) begin
			ndwi_d = '0;
		end else begin
			ndwi_d = wrow[NC].neg ? 15'(15'd0 - mag_w) : mag_w;
		end
		if (srow[NC].zero) begin
			bright_d = '0;
		end else if (srow[NC].sat) begin
			bright_d = sip_pkg::BrightMax;
		end else begin
			bright_d = srow[NC].root
				+ 15'(srow[NC].rem > {2'b00, srow[NC].root});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ch.ready) begin
			out_valid_q <= v_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ch.ready) begin
			ndvi_q <= ndvi_d;
			ndwi_q <= ndwi_d;
			bright_q <= bright_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.ndvi_value = ndvi_q;
	assign out_ch.ndwi_value = ndwi_q;
	assign out_ch.brightness_value = bright_q;

endmodule
